@@ hdl/wsrx_pkg.sv @@
package wsrx_pkg;

   localparam int LenWidth = 63;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // Error codes reported on the result channel.
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_CTRL_EXT_LEN = 2'd1;
   localparam logic [1:0] ERR_LEN_TOP_BIT  = 2'd2;

   typedef enum logic [6:0] {
      ST_HDR1    = 7'b0000001,
      ST_LEN     = 7'b0000010,
      ST_L16A    = 7'b0000100,
      ST_L16B    = 7'b0001000,
      ST_L64     = 7'b0010000,
      ST_KEY     = 7'b0100000,
      ST_PAYLOAD = 7'b1000000
   } parse_state_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       data_valid;
      logic       frame_done;
      logic [1:0] error_code;
      logic [3:0] frame_opcode;
      logic       fin_flag;
      logic [2:0] reserved_bits;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_push_type;

endpackage

@@ hdl/wsrx_ifs.sv @@
interface wsrx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsrx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       data_valid;
   logic       frame_done;
   logic [1:0] error_code;
   logic [3:0] frame_opcode;
   logic       fin_flag;
   logic [2:0] reserved_bits;

   modport source (output valid, output payload_byte, output data_valid, output frame_done,
                   output error_code, output frame_opcode, output fin_flag,
                   output reserved_bits, input ready);
   modport sink (input valid, input payload_byte, input data_valid, input frame_done,
                 input error_code, input frame_opcode, input fin_flag,
                 input reserved_bits, output ready);
endinterface

@@ hdl/wsrx_rsp_buf.sv @@
module wsrx_rsp_buf
   import wsrx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         push_ready,
   output logic         out_valid,
   output rsp_word_type out_word,
   input  logic         out_ready
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_ff, main_in;
   rsp_word_type skid_ff, skid_in;
   logic         pop;

   // The skid entry is only filled when the main entry is stalled, so a push is
   // possible whenever the skid entry is empty.
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_word   = main_ff;
   assign pop        = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push.valid;
            main_in       = push.word;
         end
      end else if (push.valid) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = push.word;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push.word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ hdl/websocket_frame_rx_parser.sv @@
// Channel   Interface     Direction  Contents
// req_ch    wsrx_req_if   in         one received frame byte per word
// rsp_ch    wsrx_rsp_if   out        unmasked payload byte, frame end, error, header fields
//
// One received byte is parsed per clock while the output buffer has room; the state
// update is done in the cycle a byte is accepted and any result word is registered.
// Header bytes that do not end a frame produce no result word.
// A two-entry output buffer keeps req_ch.ready high while one result waits; input
// stalls only when both entries are full.
// Synchronous active-high reset returns the parser to waiting for a first header byte.
module websocket_frame_rx_parser
   import wsrx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wsrx_req_if.sink   req_ch,
   wsrx_rsp_if.source rsp_ch
);

   parse_state_type      state_ff, state_in;
   logic [LenWidth-1:0]  rem_len_ff, rem_len_in;
   logic [31:0]          mask_key_ff, mask_key_in;
   logic [1:0]           mask_pos_ff, mask_pos_in;
   logic [2:0]           len_cnt_ff, len_cnt_in;
   logic [1:0]           key_cnt_ff, key_cnt_in;
   logic                 masked_ff, masked_in;
   logic [3:0]           opcode_ff, opcode_in;
   logic                 fin_ff, fin_in;
   logic [2:0]           rsv_ff, rsv_in;

   logic                 accept;
   logic [7:0]           c;
   logic [LenWidth-1:0]  len_shift;
   logic [LenWidth-1:0]  len_dec;
   rsp_push_type         push;
   logic                 push_ready;
   rsp_word_type         out_word;

   assign c         = req_ch.rx_byte;
   assign accept    = req_ch.valid && push_ready;
   assign len_shift = {rem_len_ff[LenWidth-9:0], c};
   assign len_dec   = rem_len_ff - {{(LenWidth-1){1'b0}}, 1'b1};

   always_comb begin
      state_in    = state_ff;
      rem_len_in  = rem_len_ff;
      mask_key_in = mask_key_ff;
      mask_pos_in = mask_pos_ff;
      len_cnt_in  = len_cnt_ff;
      key_cnt_in  = key_cnt_ff;
      masked_in   = masked_ff;
      opcode_in   = opcode_ff;
      fin_in      = fin_ff;
      rsv_in      = rsv_ff;

      push.valid              = 1'b0;
      push.word.payload_byte  = 8'd0;
      push.word.data_valid    = 1'b0;
      push.word.frame_done    = 1'b0;
      push.word.error_code    = ERR_NONE;
      push.word.frame_opcode  = opcode_ff;
      push.word.fin_flag      = fin_ff;
      push.word.reserved_bits = rsv_ff;

      if (accept) begin
         unique case (state_ff)
            ST_HDR1: begin
               opcode_in = c[3:0];
               rsv_in    = c[6:4];
               fin_in    = c[7];
               state_in  = ST_LEN;
            end
            ST_LEN: begin
               masked_in = c[7];
               if (c[6:0] == LEN_CODE_16 || c[6:0] == LEN_CODE_64) begin
                  if (opcode_ff[3]) begin
                     state_in             = ST_HDR1;
                     push.valid           = 1'b1;
                     push.word.error_code = ERR_CTRL_EXT_LEN;
                  end else begin
                     rem_len_in = '0;
                     len_cnt_in = 3'd0;
                     state_in   = (c[6:0] == LEN_CODE_16) ? ST_L16A : ST_L64;
                  end
               end else begin
                  rem_len_in = {{(LenWidth-7){1'b0}}, c[6:0]};
                  if (c[7]) begin
                     key_cnt_in = 2'd0;
                     state_in   = ST_KEY;
                  end else if (c[6:0] == 7'd0) begin
                     state_in             = ST_HDR1;
                     push.valid           = 1'b1;
                     push.word.frame_done = 1'b1;
                  end else begin
                     state_in = ST_PAYLOAD;
                  end
               end
            end
            ST_L16A: begin
               rem_len_in = {{(LenWidth-16){1'b0}}, c, 8'd0};
               state_in   = ST_L16B;
            end
            ST_L16B: begin
               rem_len_in = {rem_len_ff[LenWidth-1:8], c};
               if (masked_ff) begin
                  key_cnt_in = 2'd0;
                  state_in   = ST_KEY;
               end else if (rem_len_ff[15:8] == 8'd0 && c == 8'd0) begin
                  state_in             = ST_HDR1;
                  push.valid           = 1'b1;
                  push.word.frame_done = 1'b1;
               end else begin
                  state_in = ST_PAYLOAD;
               end
            end
            ST_L64: begin
               if (len_cnt_ff == 3'd0 && c[7]) begin
                  state_in             = ST_HDR1;
                  push.valid           = 1'b1;
                  push.word.error_code = ERR_LEN_TOP_BIT;
               end else begin
                  rem_len_in = len_shift;
                  len_cnt_in = len_cnt_ff + 3'd1;
                  if (len_cnt_ff == 3'd7) begin
                     if (masked_ff) begin
                        key_cnt_in = 2'd0;
                        state_in   = ST_KEY;
                     end else if (len_shift == '0) begin
                        state_in             = ST_HDR1;
                        push.valid           = 1'b1;
                        push.word.frame_done = 1'b1;
                     end else begin
                        state_in = ST_PAYLOAD;
                     end
                  end
               end
            end
            ST_KEY: begin
               // Key bytes are stored in arrival order, first byte lowest.
               mask_key_in[key_cnt_ff*8 +: 8] = c;
               key_cnt_in = key_cnt_ff + 2'd1;
               if (key_cnt_ff == 2'd3) begin
                  mask_pos_in = 2'd0;
                  if (rem_len_ff == '0) begin
                     state_in             = ST_HDR1;
                     push.valid           = 1'b1;
                     push.word.frame_done = 1'b1;
                  end else begin
                     state_in = ST_PAYLOAD;
                  end
               end
            end
            ST_PAYLOAD: begin
               push.valid           = 1'b1;
               push.word.data_valid = 1'b1;
               if (masked_ff) begin
                  push.word.payload_byte = c ^ mask_key_ff[mask_pos_ff*8 +: 8];
                  mask_pos_in            = mask_pos_ff + 2'd1;
               end else begin
                  push.word.payload_byte = c;
               end
               rem_len_in = len_dec;
               if (len_dec == '0) begin
                  state_in             = ST_HDR1;
                  push.word.frame_done = 1'b1;
               end
            end
            default: begin
               state_in = ST_HDR1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HDR1;
         rem_len_ff  <= '0;
         mask_key_ff <= '0;
         mask_pos_ff <= 2'd0;
         len_cnt_ff  <= 3'd0;
         key_cnt_ff  <= 2'd0;
         masked_ff   <= 1'b0;
         opcode_ff   <= 4'd0;
         fin_ff      <= 1'b0;
         rsv_ff      <= 3'd0;
      end else begin
         state_ff    <= state_in;
         rem_len_ff  <= rem_len_in;
         mask_key_ff <= mask_key_in;
         mask_pos_ff <= mask_pos_in;
         len_cnt_ff  <= len_cnt_in;
         key_cnt_ff  <= key_cnt_in;
         masked_ff   <= masked_in;
         opcode_ff   <= opcode_in;
         fin_ff      <= fin_in;
         rsv_ff      <= rsv_in;
      end
   end

   wsrx_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .out_valid  (rsp_ch.valid),
      .out_word   (out_word),
      .out_ready  (rsp_ch.ready)
   );

   assign req_ch.ready         = push_ready;
   assign rsp_ch.payload_byte  = out_word.payload_byte;
   assign rsp_ch.data_valid    = out_word.data_valid;
   assign rsp_ch.frame_done    = out_word.frame_done;
   assign rsp_ch.error_code    = out_word.error_code;
   assign rsp_ch.frame_opcode  = out_word.frame_opcode;
   assign rsp_ch.fin_flag      = out_word.fin_flag;
   assign rsp_ch.reserved_bits = out_word.reserved_bits;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import wsrx_pkg::*;

   localparam int RandomBytes = 1700;
   localparam int DirectedRows = 24;
   localparam int IdlePercent = 22;

   typedef struct {
      logic [7:0]   rx_byte;
      bit           typed;
      rsp_word_type word;
   } stim_row_type;

   localparam rsp_word_type NO_WORD = '0;

   logic clock;
   logic reset;

   wsrx_req_if req_ch ();
   wsrx_rsp_if rsp_ch ();

   websocket_frame_rx_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   stim_row_type   directed_rows[DirectedRows];
   stim_row_type   stim_rows[$];
   rsp_word_type   expected_words[$];
   int             next_row = 0;
   int             error_count = 0;
   logic           hold_off;
   logic           quiet;

   // Frame parser state, kept in step with the accepted byte stream.
   parse_state_type frame_state = ST_HDR1;
   logic [2:0]      len_idx = '0;
   logic [1:0]      key_idx = '0;
   logic [62:0]     bytes_left = '0;
   logic [31:0]     key_word = '0;
   logic [1:0]      key_pos = '0;
   logic            masked = 1'b0;
   logic [3:0]      opcode_hold = '0;
   logic            fin_hold = 1'b0;
   logic [2:0]      rsv_hold = '0;

   assign quiet = (next_row >= 800) && (next_row < 1100);

   always #1 clock = ~clock;

   function automatic rsp_word_type frame_word(input logic [7:0] data, input logic valid,
                                               input logic done, input logic [1:0] err);
      rsp_word_type w;
      w.payload_byte = data;
      w.data_valid = valid;
      w.frame_done = done;
      w.error_code = err;
      w.frame_opcode = opcode_hold;
      w.fin_flag = fin_hold;
      w.reserved_bits = rsv_hold;
      return w;
   endfunction

   // The length is known: next come the mask key, the payload, or the frame end.
   function automatic bit length_complete(output rsp_word_type w);
      w = NO_WORD;
      if (masked) begin
         frame_state = ST_KEY;
         key_idx = '0;
         return 1'b0;
      end
      if (bytes_left == '0) begin
         frame_state = ST_HDR1;
         w = frame_word(8'h00, 1'b0, 1'b1, ERR_NONE);
         return 1'b1;
      end
      frame_state = ST_PAYLOAD;
      return 1'b0;
   endfunction

   function automatic bit parse_byte(input logic [7:0] c, output rsp_word_type w);
      bit         produced;
      logic [7:0] data;
      logic       done;
      produced = 1'b0;
      w = NO_WORD;
      case (frame_state)
         ST_HDR1: begin
            opcode_hold = c[3:0];
            rsv_hold = c[6:4];
            fin_hold = c[7];
            frame_state = ST_LEN;
         end
         ST_LEN: begin
            masked = c[7];
            if (c[6:0] == LEN_CODE_16 || c[6:0] == LEN_CODE_64) begin
               if (opcode_hold[3]) begin
                  frame_state = ST_HDR1;
                  w = frame_word(8'h00, 1'b0, 1'b0, ERR_CTRL_EXT_LEN);
                  produced = 1'b1;
               end else begin
                  bytes_left = '0;
                  len_idx = '0;
                  frame_state = (c[6:0] == LEN_CODE_16) ? ST_L16A : ST_L64;
               end
            end else begin
               bytes_left = {56'd0, c[6:0]};
               produced = length_complete(w);
            end
         end
         ST_L16A: begin
            bytes_left = {47'd0, c, 8'h00};
            frame_state = ST_L16B;
         end
         ST_L16B: begin
            bytes_left[7:0] = c;
            produced = length_complete(w);
         end
         ST_L64: begin
            if (len_idx == 3'd0 && c[7]) begin
               frame_state = ST_HDR1;
               w = frame_word(8'h00, 1'b0, 1'b0, ERR_LEN_TOP_BIT);
               produced = 1'b1;
            end else begin
               bytes_left = {bytes_left[54:0], c};
               if (len_idx == 3'd7)
                  produced = length_complete(w);
               else
                  len_idx = len_idx + 3'd1;
            end
         end
         ST_KEY: begin
            key_word[8*key_idx +: 8] = c;
            if (key_idx != 2'd3) begin
               key_idx = key_idx + 2'd1;
            end else begin
               key_pos = '0;
               if (bytes_left == '0) begin
                  frame_state = ST_HDR1;
                  w = frame_word(8'h00, 1'b0, 1'b1, ERR_NONE);
                  produced = 1'b1;
               end else begin
                  frame_state = ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            data = c;
            if (masked) begin
               data = data ^ key_word[8*key_pos +: 8];
               key_pos = key_pos + 2'd1;
            end
            bytes_left = bytes_left - 63'd1;
            done = (bytes_left == '0);
            if (done)
               frame_state = ST_HDR1;
            w = frame_word(data, 1'b1, done, ERR_NONE);
            produced = 1'b1;
         end
         default: frame_state = ST_HDR1;
      endcase
      return produced;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      stim_row_type row;
      row.rx_byte = b;
      row.typed = 1'b0;
      row.word = NO_WORD;
      stim_rows.push_back(row);
   endfunction

   // Appends one frame with random content; a few are deliberately malformed.
   function automatic void add_frame();
      int          kind;
      int          enc;
      logic [7:0]  hdr;
      logic        mask_bit;
      logic [15:0] n;
      kind = $urandom_range(0, 99);
      hdr = 8'($urandom_range(0, 255));
      mask_bit = 1'($urandom_range(0, 1));
      if (kind < 6) begin
         // Control opcode with an extended length code.
         hdr[3] = 1'b1;
         push_byte(hdr);
         push_byte({mask_bit, $urandom_range(0, 1) ? LEN_CODE_64 : LEN_CODE_16});
         return;
      end
      if (kind < 10) begin
         // Top bit set in the first byte of a 64-bit length.
         hdr[3] = 1'b0;
         push_byte(hdr);
         push_byte({mask_bit, LEN_CODE_64});
         push_byte(8'h80 | 8'($urandom_range(0, 127)));
         return;
      end
      enc = $urandom_range(0, 9);
      if (enc >= 7)
         hdr[3] = 1'b0;
      push_byte(hdr);
      if (enc < 7) begin
         n = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 125)
                                              : $urandom_range(0, 12));
         push_byte({mask_bit, n[6:0]});
      end else if (enc < 9) begin
         n = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                              : $urandom_range(0, 20));
         push_byte({mask_bit, LEN_CODE_16});
         push_byte(n[15:8]);
         push_byte(n[7:0]);
      end else begin
         n = 16'($urandom_range(0, 20));
         push_byte({mask_bit, LEN_CODE_64});
         repeat (6) push_byte(8'h00);
         push_byte(n[15:8]);
         push_byte(n[7:0]);
      end
      if (mask_bit)
         repeat (4) push_byte(8'($urandom_range(0, 255)));
      repeat (n) push_byte(8'($urandom_range(0, 255)));
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Sender: offers the next byte and runs the parser model on each accepted word.
   always @(posedge clock) begin : byte_feed
      logic         offer;
      bit           produced;
      rsp_word_type predicted;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.rx_byte <= 8'h00;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            produced = parse_byte(stim_rows[next_row].rx_byte, predicted);
            if (stim_rows[next_row].typed)
               expected_words.push_back(stim_rows[next_row].word);
            else if (produced)
               expected_words.push_back(predicted);
            next_row++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            offer = (next_row < stim_rows.size()) &&
                    (quiet || $urandom_range(0, 99) >= IdlePercent);
            req_ch.valid <= offer;
            if (offer)
               req_ch.rx_byte <= stim_rows[next_row].rx_byte;
         end
      end
   end

   // Receiver: checks each accepted result word against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.payload_byte, rsp_ch.data_valid, rsp_ch.frame_done, rsp_ch.error_code,
                rsp_ch.frame_opcode, rsp_ch.fin_flag, rsp_ch.reserved_bits};
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %0h", $time, got);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("payload_byte", want.payload_byte, got.payload_byte);
            check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
            check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
            check_field("error_code", 8'(want.error_code), 8'(got.error_code));
            check_field("frame_opcode", 8'(want.frame_opcode), 8'(got.frame_opcode));
            check_field("fin_flag", 8'(want.fin_flag), 8'(got.fin_flag));
            check_field("reserved_bits", 8'(want.reserved_bits), 8'(got.reserved_bits));
         end
      end
      rsp_ch.ready <= !reset && !hold_off &&
                      (quiet || $urandom_range(0, 99) >= IdlePercent);
   end

   // One long hold-off on the result side so the output buffer fills and input stalls.
   initial begin
      wait (next_row >= 400);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      hold_off = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;

      // Close with a 16-bit length, 64-bit length with its top bit set, empty ping,
      // one unmasked byte, a masked two-byte frame and an empty masked pong.
      directed_rows = '{
         '{8'h88, 1'b0, NO_WORD},
         '{8'h7e, 1'b1, rsp_word_type'{8'h00, 1'b0, 1'b0, ERR_CTRL_EXT_LEN, 4'h8, 1'b1, 3'h0}},
         '{8'h02, 1'b0, NO_WORD},
         '{8'h7f, 1'b0, NO_WORD},
         '{8'h80, 1'b1, rsp_word_type'{8'h00, 1'b0, 1'b0, ERR_LEN_TOP_BIT, 4'h2, 1'b0, 3'h0}},
         '{8'hf9, 1'b0, NO_WORD},
         '{8'h00, 1'b1, rsp_word_type'{8'h00, 1'b0, 1'b1, ERR_NONE, 4'h9, 1'b1, 3'h7}},
         '{8'h81, 1'b0, NO_WORD},
         '{8'h01, 1'b0, NO_WORD},
         '{8'hff, 1'b1, rsp_word_type'{8'hff, 1'b1, 1'b1, ERR_NONE, 4'h1, 1'b1, 3'h0}},
         '{8'h82, 1'b0, NO_WORD},
         '{8'h82, 1'b0, NO_WORD},
         '{8'h12, 1'b0, NO_WORD},
         '{8'h34, 1'b0, NO_WORD},
         '{8'h56, 1'b0, NO_WORD},
         '{8'h78, 1'b0, NO_WORD},
         '{8'haa, 1'b0, NO_WORD},
         '{8'h55, 1'b0, NO_WORD},
         '{8'h8a, 1'b0, NO_WORD},
         '{8'h80, 1'b0, NO_WORD},
         '{8'h00, 1'b0, NO_WORD},
         '{8'h00, 1'b0, NO_WORD},
         '{8'h00, 1'b0, NO_WORD},
         '{8'hff, 1'b1, rsp_word_type'{8'h00, 1'b0, 1'b1, ERR_NONE, 4'ha, 1'b1, 3'h0}}
      };
      foreach (directed_rows[i])
         stim_rows.push_back(directed_rows[i]);
      while (stim_rows.size() < DirectedRows + RandomBytes)
         add_frame();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (next_row < stim_rows.size())
         @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
